/* hdl/adts_pkg.sv */
// Package with the shared types and constants of the ADTS frame sync block.
package adts_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 13;

  localparam logic [ByteW-1:0] SyncByte   = 8'hFF;
  localparam logic [3:0]       SyncNibble = 4'hF;
  localparam logic [LenW-1:0]  HdrBytes   = 13'd7;

  typedef enum logic [7:0] {
    PhHunt    = 8'b0000_0001,
    PhSync2   = 8'b0000_0010,
    PhHdr3    = 8'b0000_0100,
    PhHdr4    = 8'b0000_1000,
    PhHdr5    = 8'b0001_0000,
    PhHdr6    = 8'b0010_0000,
    PhHdr7    = 8'b0100_0000,
    PhPayload = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             kept;
    logic             is_header;
    logic             frame_first;
    logic             frame_last;
    logic [LenW-1:0]  length_out;
  } result_t;

endpackage

/* hdl/adts_frame_sync_core.sv */
// ADTS frame sync core: marks header, payload and frame bounds on a byte stream.
//
// The core takes one ADTS byte per transfer and returns one result per byte,
// in order, registered and offered in the cycle after the input transfer. The
// result sits in an output register, and a new byte is accepted in every cycle
// in which that register is empty or is being emptied, so the sustained rate is
// one byte per clock cycle while out_ready_i is high; the frame length field
// and the payload counter take at most one 13-bit add or subtract per byte.
module adts_frame_sync_core
  import adts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ByteW-1:0]    in_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ByteW-1:0]    out_byte_o,
  output logic                kept_o,
  output logic                is_header_o,
  output logic                frame_first_o,
  output logic                frame_last_o,
  output logic [LenW-1:0]     length_out_o
);

  phase_e          phase_q, phase_d;
  logic [LenW-1:0] frame_len_q, frame_len_d;
  logic [LenW-1:0] bytes_left_q, bytes_left_d;
  logic            out_valid_q, out_valid_d;
  result_t         res_q, res_d;
  logic            in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    phase_d               = phase_q;
    frame_len_d           = frame_len_q;
    bytes_left_d          = bytes_left_q;
    res_d                 = '0;
    res_d.out_byte        = in_byte_i;
    case (phase_q)
      PhHunt: begin
        if (in_byte_i == SyncByte) begin
          phase_d           = PhSync2;
          res_d.kept        = 1'b1;
          res_d.is_header   = 1'b1;
          res_d.frame_first = 1'b1;
        end
      end
      PhSync2: begin
        if (in_byte_i[7:4] == SyncNibble) begin
          phase_d         = PhHdr3;
          res_d.kept      = 1'b1;
          res_d.is_header = 1'b1;
        end else begin
          phase_d = PhHunt;
        end
      end
      PhHdr3: begin
        phase_d         = PhHdr4;
        res_d.kept      = 1'b1;
        res_d.is_header = 1'b1;
      end
      PhHdr4: begin
        frame_len_d     = {in_byte_i[1:0], 11'd0};
        phase_d         = PhHdr5;
        res_d.kept      = 1'b1;
        res_d.is_header = 1'b1;
      end
      PhHdr5: begin
        frame_len_d     = frame_len_q + {2'd0, in_byte_i, 3'd0};
        phase_d         = PhHdr6;
        res_d.kept      = 1'b1;
        res_d.is_header = 1'b1;
      end
      PhHdr6: begin
        frame_len_d     = frame_len_q + {10'd0, in_byte_i[7:5]};
        phase_d         = PhHdr7;
        res_d.kept      = 1'b1;
        res_d.is_header = 1'b1;
      end
      PhHdr7: begin
        res_d.kept      = 1'b1;
        res_d.is_header = 1'b1;
        if (frame_len_q <= HdrBytes) begin
          bytes_left_d      = '0;
          phase_d           = PhHunt;
          res_d.frame_last  = 1'b1;
          res_d.length_out  = frame_len_q;
        end else begin
          bytes_left_d = frame_len_q - HdrBytes;
          phase_d      = PhPayload;
        end
      end
      PhPayload: begin
        res_d.kept = 1'b1;
        if (bytes_left_q[LenW-1:1] == '0) begin
          bytes_left_d     = '0;
          phase_d          = PhHunt;
          res_d.frame_last = 1'b1;
          res_d.length_out = frame_len_q;
        end else begin
          bytes_left_d = bytes_left_q - 13'd1;
        end
      end
      default: begin
        phase_d = PhHunt;
      end
    endcase
  end

  assign out_valid_d = in_fire || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHunt;
      frame_len_q  <= '0;
      bytes_left_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        phase_q      <= phase_d;
        frame_len_q  <= frame_len_d;
        bytes_left_q <= bytes_left_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = res_q.out_byte;
  assign kept_o        = res_q.kept;
  assign is_header_o   = res_q.is_header;
  assign frame_first_o = res_q.frame_first;
  assign frame_last_o  = res_q.frame_last;
  assign length_out_o  = res_q.length_out;

endmodule

/* hdl/adts_chk.sv */
// Checker with port assertions for the ADTS frame sync core, and its bind.
module adts_chk
  import adts_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic [ByteW-1:0] in_byte_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [ByteW-1:0] out_byte_o,
  input logic             kept_o,
  input logic             is_header_o,
  input logic             frame_first_o,
  input logic             frame_last_o,
  input logic [LenW-1:0]  length_out_o
);

  // A stalled result stays offered with its byte, frame end mark and length unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(frame_last_o) && $stable(length_out_o))
    else $error("stalled result changed");

  // An accepted byte is offered as a result in the next cycle.
  a_in_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o && out_byte_o == $past(in_byte_i))
    else $error("accepted byte not passed to the result");

  // A frame start is always a kept header byte and never ends the frame.
  a_first_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_first_o |-> kept_o && is_header_o && !frame_last_o
      && out_byte_o == SyncByte)
    else $error("frame start without header marks");

  // A discarded byte carries no marks.
  a_drop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kept_o |-> !is_header_o && !frame_first_o && !frame_last_o
      && length_out_o == '0)
    else $error("discarded byte carries marks");

  // The length is shown only with the end of a frame.
  a_len_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_last_o |-> length_out_o == '0)
    else $error("length shown outside frame end");

endmodule

bind adts_frame_sync_core adts_chk u_adts_chk (.*);
